>>> design/vpcc_pkg.sv
`default_nettype none
package vpcc_pkg;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic [15:0]        heading;
		logic signed [15:0] time_stamp;
	} in_item_t;

	typedef struct packed {
		logic       valid_res;
		logic [2:0] cause;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [45:0] data;
	} cfg_item_t;

	localparam logic [2:0] OP_CLEAR      = 3'd0;
	localparam logic [2:0] OP_ADD_STATIC = 3'd1;
	localparam logic [2:0] OP_ADD_DYN    = 3'd2;
	localparam logic [2:0] OP_ADD_CONS   = 3'd3;
	localparam logic [2:0] OP_QUERY      = 3'd4;

	localparam logic [2:0] CAUSE_OK      = 3'd0;
	localparam logic [2:0] CAUSE_MAP     = 3'd1;
	localparam logic [2:0] CAUSE_STATIC  = 3'd2;
	localparam logic [2:0] CAUSE_DYNAMIC = 3'd3;
	localparam logic [2:0] CAUSE_CONS    = 3'd4;
	localparam logic [2:0] CAUSE_FULL    = 3'd5;

	localparam logic [2:0] REG_X_LIMIT   = 3'd0;
	localparam logic [2:0] REG_Y_LIMIT   = 3'd1;
	localparam logic [2:0] REG_REAR      = 3'd2;
	localparam logic [2:0] REG_FRONT     = 3'd3;
	localparam logic [2:0] REG_SIDE      = 3'd4;
	localparam logic [2:0] REG_CLEAR_SQ  = 3'd5;
	localparam logic [2:0] REG_WAIT      = 3'd6;

	// Unit operations.
	typedef enum logic [1:0] {
		UOP_BOX  = 2'd0,
		UOP_DIST = 2'd1
	} uop_t;

	typedef struct packed {
		logic [22:0] rear;
		logic [22:0] front;
		logic [22:0] side;
		logic [45:0] clear_sq;
	} geom_cfg_t;

	function automatic logic signed [15:0] quarter_sine(input logic [6:0] k);
		logic signed [15:0] v;
		unique case (k)
			7'd0: v = 16'sd0;      7'd1: v = 16'sd402;    7'd2: v = 16'sd804;
			7'd3: v = 16'sd1205;   7'd4: v = 16'sd1606;   7'd5: v = 16'sd2006;
			7'd6: v = 16'sd2404;   7'd7: v = 16'sd2801;   7'd8: v = 16'sd3196;
			7'd9: v = 16'sd3590;   7'd10: v = 16'sd3981;  7'd11: v = 16'sd4370;
			7'd12: v = 16'sd4756;  7'd13: v = 16'sd5139;  7'd14: v = 16'sd5520;
			7'd15: v = 16'sd5897;  7'd16: v = 16'sd6270;  7'd17: v = 16'sd6639;
			7'd18: v = 16'sd7005;  7'd19: v = 16'sd7366;  7'd20: v = 16'sd7723;
			7'd21: v = 16'sd8076;  7'd22: v = 16'sd8423;  7'd23: v = 16'sd8765;
			7'd24: v = 16'sd9102;  7'd25: v = 16'sd9434;  7'd26: v = 16'sd9760;
			7'd27: v = 16'sd10080; 7'd28: v = 16'sd10394; 7'd29: v = 16'sd10702;
			7'd30: v = 16'sd11003; 7'd31: v = 16'sd11297; 7'd32: v = 16'sd11585;
			7'd33: v = 16'sd11866; 7'd34: v = 16'sd12140; 7'd35: v = 16'sd12406;
			7'd36: v = 16'sd12665; 7'd37: v = 16'sd12916; 7'd38: v = 16'sd13160;
			7'd39: v = 16'sd13395; 7'd40: v = 16'sd13623; 7'd41: v = 16'sd13842;
			7'd42: v = 16'sd14053; 7'd43: v = 16'sd14256; 7'd44: v = 16'sd14449;
			7'd45: v = 16'sd14635; 7'd46: v = 16'sd14811; 7'd47: v = 16'sd14978;
			7'd48: v = 16'sd15137; 7'd49: v = 16'sd15286; 7'd50: v = 16'sd15426;
			7'd51: v = 16'sd15557; 7'd52: v = 16'sd15679; 7'd53: v = 16'sd15791;
			7'd54: v = 16'sd15893; 7'd55: v = 16'sd15986; 7'd56: v = 16'sd16069;
			7'd57: v = 16'sd16143; 7'd58: v = 16'sd16207; 7'd59: v = 16'sd16261;
			7'd60: v = 16'sd16305; 7'd61: v = 16'sd16340; 7'd62: v = 16'sd16364;
			7'd63: v = 16'sd16379;
			default: v = 16'sd16384;
		endcase
		return v;
	endfunction

	function automatic logic signed [15:0] sine_rom(input logic [7:0] idx);
		logic [6:0]         k;
		logic signed [15:0] v;
		k = {1'b0, idx[5:0]};
		v = idx[6] ? quarter_sine(7'd64 - k) : quarter_sine(k);
		return idx[7] ? -v : v;
	endfunction

endpackage
`default_nettype wire

>>> design/vpcc_geom_unit.sv
`default_nettype none
// Shared geometry unit: a three-stage pipe that computes either the rotated-box
// hit or the squared-distance hit for one stored entry per cycle.
module vpcc_geom_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire vpcc_pkg::uop_t     uop,
	input  wire logic signed [24:0] dx,
	input  wire logic signed [24:0] dy,
	input  wire logic signed [15:0] sin_v,
	input  wire logic signed [15:0] cos_v,
	input  wire vpcc_pkg::geom_cfg_t cfg,
	output logic                    done,
	output logic                    hit
);
	import vpcc_pkg::*;

	logic               v_s1, v_s2;
	uop_t               op_s1, op_s2;
	logic signed [40:0] p0_s1, p1_s1, p2_s1, p3_s1;
	logic signed [49:0] q0_s1, q1_s1;
	logic signed [41:0] lon_s2, lat_s2;
	logic [50:0]        d2_s2;
	logic signed [38:0] r_w, f_w, w_w;

	assign r_w = $signed({2'b0, cfg.rear, 14'd0});
	assign f_w = $signed({2'b0, cfg.front, 14'd0});
	assign w_w = $signed({2'b0, cfg.side, 14'd0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			done <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= uop;
		p0_s1 <= dx * cos_v;
		p1_s1 <= dy * sin_v;
		p2_s1 <= dx * sin_v;
		p3_s1 <= dy * cos_v;
		q0_s1 <= dx * dx;
		q1_s1 <= dy * dy;
		op_s2 <= op_s1;
		lon_s2 <= 42'(p0_s1) - 42'(p1_s1);
		lat_s2 <= 42'(p2_s1) + 42'(p3_s1);
		d2_s2 <= 51'(unsigned'(q0_s1)) + 51'(unsigned'(q1_s1));
		unique case (op_s2)
			UOP_BOX: hit <= (lon_s2 > -42'(r_w)) && (lon_s2 < 42'(f_w)) &&
				(lat_s2 > -42'(w_w)) && (lat_s2 < 42'(w_w));
			default: hit <= d2_s2 < 51'(cfg.clear_sq);
		endcase
	end

	always_ff @(posedge clk) begin
		if (arst_n && v_s2) begin
			assert (op_s2 == UOP_BOX || op_s2 == UOP_DIST)
				else $error("unknown unit op");
		end
	end

	a_pipe_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ##2 done) else $error("unit latency broken");
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 3)) else $error("spurious unit done");
	a_dist_pos: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && op_s2 == UOP_DIST |-> !d2_s2[50]) else $error("distance overflow");
endmodule
`default_nettype wire

>>> design/vehicle_pose_collision_checker_unit.sv
`default_nettype none
// Flow: loads, clear, unknown codes and queries outside the map pass through ST_DONE,
// which raises out_valid. A query inside the map passes ST_SETUP, ST_NEXT, then ST_READ,
// ST_CHECK, ST_WAIT per stored entry visited (static, then dynamic, then constraint):
// read, register, then the 3-stage geometry unit; a hit ends the walk at that entry.
// Throughput: one transaction at a time; in_ready is low until the result is taken.
// Reset clears the store counts, the registers to their defaults and all control state.
module vehicle_pose_collision_checker_unit #(
	parameter int STATIC_DEPTH     = 64,
	parameter int DYNAMIC_DEPTH    = 64,
	parameter int CONSTRAINT_DEPTH = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire vpcc_pkg::in_item_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output vpcc_pkg::out_item_t       out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire vpcc_pkg::cfg_item_t  cfg_data
);
	import vpcc_pkg::*;

	localparam int SW = $clog2(STATIC_DEPTH + 1);
	localparam int DW = $clog2(DYNAMIC_DEPTH + 1);
	localparam int CW = $clog2(CONSTRAINT_DEPTH + 1);
	localparam int SA = (STATIC_DEPTH > 1) ? $clog2(STATIC_DEPTH) : 1;
	localparam int DA = (DYNAMIC_DEPTH > 1) ? $clog2(DYNAMIC_DEPTH) : 1;
	localparam int CA = (CONSTRAINT_DEPTH > 1) ? $clog2(CONSTRAINT_DEPTH) : 1;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SETUP = 7'b0000010,
		ST_READ  = 7'b0000100,
		ST_CHECK = 7'b0001000,
		ST_WAIT  = 7'b0010000,
		ST_NEXT  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		PH_STATIC = 2'd0,
		PH_DYN    = 2'd1,
		PH_CONS   = 2'd2
	} phase_t;

	logic [22:0] x_limit_q, y_limit_q, rear_q, front_q, side_q;
	logic [45:0] clear_sq_q;
	logic [14:0] wait_q;

	logic [47:0] static_mem [STATIC_DEPTH];
	logic [63:0] dyn_mem [DYNAMIC_DEPTH];
	logic [63:0] cons_mem [CONSTRAINT_DEPTH];
	logic [SW-1:0] s_cnt_q;
	logic [DW-1:0] d_cnt_q;
	logic [CW-1:0] c_cnt_q;

	state_t state_q;
	phase_t phase_q;
	logic [12:0] idx_q;
	in_item_t    item_q;
	logic signed [15:0] sin_q, cos_q;
	logic [63:0] rd_q;
	logic        act_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        in_fire, cfg_fire;
	logic        done, hit;
	logic [7:0]  hidx;
	logic [12:0] cnt_cur;
	logic signed [24:0] dx_w, dy_w;
	logic signed [23:0] ex, ey;
	logic signed [15:0] et;
	logic signed [16:0] t_w, k_w, neg_t;
	logic signed [17:0] win_end;
	logic        rd_act;
	geom_cfg_t   gcfg;

	assign in_fire   = in_valid && in_ready;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_limit_q  <= 23'd25600;
			y_limit_q  <= 23'd25600;
			rear_q     <= 23'd384;
			front_q    <= 23'd896;
			side_q     <= 23'd384;
			clear_sq_q <= 46'd4194304;
			wait_q     <= 15'd10;
		end else if (cfg_fire) begin
			unique case (cfg_data.index)
				REG_X_LIMIT:  x_limit_q  <= cfg_data.data[22:0];
				REG_Y_LIMIT:  y_limit_q  <= cfg_data.data[22:0];
				REG_REAR:     rear_q     <= cfg_data.data[22:0];
				REG_FRONT:    front_q    <= cfg_data.data[22:0];
				REG_SIDE:     side_q     <= cfg_data.data[22:0];
				REG_CLEAR_SQ: clear_sq_q <= cfg_data.data;
				REG_WAIT:     wait_q     <= cfg_data.data[14:0];
				default: ;
			endcase
		end
	end

	assign gcfg = '{rear: rear_q, front: front_q, side: side_q, clear_sq: clear_sq_q};

	// Stores, written by loads and read one entry per visit.
	always_ff @(posedge clk) begin
		if (in_fire && in_data.opcode == OP_ADD_STATIC && s_cnt_q < SW'(STATIC_DEPTH))
			static_mem[s_cnt_q[SA-1:0]] <= {in_data.pos_x, in_data.pos_y};
		if (in_fire && in_data.opcode == OP_ADD_DYN && d_cnt_q < DW'(DYNAMIC_DEPTH))
			dyn_mem[d_cnt_q[DA-1:0]] <= {in_data.pos_x, in_data.pos_y, in_data.time_stamp};
		if (in_fire && in_data.opcode == OP_ADD_CONS && c_cnt_q < CW'(CONSTRAINT_DEPTH))
			cons_mem[c_cnt_q[CA-1:0]] <= {in_data.pos_x, in_data.pos_y, in_data.time_stamp};
		if (state_q == ST_READ) begin
			unique case (phase_q)
				PH_STATIC: rd_q <= {static_mem[idx_q[SA-1:0]], 16'd0};
				PH_DYN:    rd_q <= dyn_mem[idx_q[DA-1:0]];
				default:   rd_q <= cons_mem[idx_q[CA-1:0]];
			endcase
		end
	end

	assign ex    = $signed(rd_q[63:40]);
	assign ey    = $signed(rd_q[39:16]);
	assign et    = $signed(rd_q[15:0]);
	assign dx_w  = 25'(ex) - 25'(item_q.pos_x);
	assign dy_w  = 25'(ey) - 25'(item_q.pos_y);
	assign t_w   = 17'(item_q.time_stamp);
	assign k_w   = 17'(et);
	assign neg_t = -t_w;
	assign win_end = 18'(et) + $signed({3'b0, wait_q});

	always_comb begin
		unique case (phase_q)
			PH_STATIC: rd_act = 1'b1;
			PH_DYN:    rd_act = (k_w == t_w) || (k_w >= neg_t && k_w <= -17'sd1);
			default:   rd_act = (t_w >= k_w) && (18'(t_w) <= win_end);
		endcase
		unique case (phase_q)
			PH_STATIC: cnt_cur = 13'(s_cnt_q);
			PH_DYN:    cnt_cur = 13'(d_cnt_q);
			default:   cnt_cur = 13'(c_cnt_q);
		endcase
	end

	assign hidx = 8'((17'(item_q.heading) + 17'd128) >> 8);

	vpcc_geom_unit u_geom (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_CHECK),
		.uop    ((phase_q == PH_STATIC) ? UOP_BOX : UOP_DIST),
		.dx     (dx_w),
		.dy     (dy_w),
		.sin_v  (sin_q),
		.cos_v  (cos_q),
		.cfg    (gcfg),
		.done   (done),
		.hit    (hit)
	);

	always_ff @(posedge clk) begin
		if (in_fire)
			item_q <= in_data;
		if (state_q == ST_SETUP) begin
			sin_q <= sine_rom(hidx);
			cos_q <= sine_rom(hidx + 8'd64);
		end
		if (state_q == ST_CHECK)
			act_q <= rd_act;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_STATIC;
			idx_q       <= '0;
			s_cnt_q     <= '0;
			d_cnt_q     <= '0;
			c_cnt_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						out_q <= '{valid_res: 1'b1, cause: CAUSE_OK};
						unique case (in_data.opcode)
							OP_CLEAR: begin
								s_cnt_q <= '0;
								d_cnt_q <= '0;
								c_cnt_q <= '0;
								state_q <= ST_DONE;
							end
							OP_ADD_STATIC: begin
								if (s_cnt_q < SW'(STATIC_DEPTH)) s_cnt_q <= s_cnt_q + 1'b1;
								else out_q <= '{valid_res: 1'b0, cause: CAUSE_FULL};
								state_q <= ST_DONE;
							end
							OP_ADD_DYN: begin
								if (d_cnt_q < DW'(DYNAMIC_DEPTH)) d_cnt_q <= d_cnt_q + 1'b1;
								else out_q <= '{valid_res: 1'b0, cause: CAUSE_FULL};
								state_q <= ST_DONE;
							end
							OP_ADD_CONS: begin
								if (c_cnt_q < CW'(CONSTRAINT_DEPTH)) c_cnt_q <= c_cnt_q + 1'b1;
								else out_q <= '{valid_res: 1'b0, cause: CAUSE_FULL};
								state_q <= ST_DONE;
							end
							OP_QUERY: begin
								if (in_data.pos_x < 0 || in_data.pos_y < 0 ||
									in_data.pos_x >= $signed({1'b0, x_limit_q}) ||
									in_data.pos_y >= $signed({1'b0, y_limit_q})) begin
									out_q   <= '{valid_res: 1'b0, cause: CAUSE_MAP};
									state_q <= ST_DONE;
								end else begin
									phase_q <= PH_STATIC;
									idx_q   <= '0;
									state_q <= ST_SETUP;
								end
							end
							default: begin
								out_q   <= '{valid_res: 1'b0, cause: CAUSE_OK};
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SETUP: state_q <= ST_NEXT;
				ST_READ:  state_q <= ST_CHECK;
				ST_CHECK: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (done) begin
						if (act_q && hit) begin
							unique case (phase_q)
								PH_STATIC: out_q <= '{valid_res: 1'b0, cause: CAUSE_STATIC};
								PH_DYN:    out_q <= '{valid_res: 1'b0, cause: CAUSE_DYNAMIC};
								default:   out_q <= '{valid_res: 1'b0, cause: CAUSE_CONS};
							endcase
							state_q <= ST_DONE;
						end else begin
							idx_q   <= idx_q + 13'd1;
							state_q <= ST_NEXT;
						end
					end
				end
				ST_NEXT: begin
					// Move to the next store once the current one is exhausted.
					if (idx_q < cnt_cur) begin
						state_q <= ST_READ;
					end else begin
						idx_q <= '0;
						unique case (phase_q)
							PH_STATIC: phase_q <= PH_DYN;
							PH_DYN:    phase_q <= PH_CONS;
							default: begin
								out_q   <= '{valid_res: 1'b1, cause: CAUSE_OK};
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_DONE: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> out_valid_q) else $error("result lost");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		s_cnt_q <= SW'(STATIC_DEPTH) && d_cnt_q <= DW'(DYNAMIC_DEPTH) &&
		c_cnt_q <= CW'(CONSTRAINT_DEPTH)) else $error("count overflow");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_fire) else $error("accept while busy");
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> idx_q < cnt_cur) else $error("read past count");
endmodule
`default_nettype wire
